// ===== src/bb3_pkg.sv =====
// Shared types, constants and helpers for the 3x3 box blur.
`timescale 1ns / 1ps
package bb3_pkg;

   localparam int MAX_WIDTH = 128;
   localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW        = COL_W + 1;
   localparam int HGT_W     = 12;
   localparam int ROW_W     = HGT_W + 1;
   localparam int PIX_W     = 8;
   localparam int CSUM_W    = PIX_W + 2;
   localparam int SUM_W     = PIX_W + 4;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = RECIP_SHIFT - 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int RECIP_FOUR  = (2 ** RECIP_SHIFT) / 4;
   localparam int RECIP_SIX   = (2 ** RECIP_SHIFT + 5) / 6;
   localparam int RECIP_NINE  = (2 ** RECIP_SHIFT + 8) / 9;

   localparam logic REG_IDX_WIDTH  = 1'b0;
   localparam logic REG_IDX_HEIGHT = 1'b1;

   localparam logic [7:0]       WIDTH_RESET  = 8'd100;
   localparam logic [HGT_W-1:0] HEIGHT_RESET = 12'd100;

   typedef struct packed {
      logic             func;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_last;
   } rsp_type;

   // Per-item control carried down the pipeline.
   typedef struct packed {
      logic valid;
      logic emit;
      logic top_en;
      logic bot_en;
      logic left_en;
      logic right_en;
      logic last;
   } ctl_type;

   typedef logic [2:0][PIX_W-1:0] pix3_type;

   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } line_pair_type;

   typedef enum logic [1:0] {
      CNT_FOUR,
      CNT_SIX,
      CNT_NINE
   } cnt_type;

   function automatic logic [RECIP_W-1:0] recip(input cnt_type cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         CNT_FOUR: r = RECIP_W'(RECIP_FOUR);
         CNT_SIX:  r = RECIP_W'(RECIP_SIX);
         CNT_NINE: r = RECIP_W'(RECIP_NINE);
         default:  r = RECIP_W'(RECIP_NINE);
      endcase
      return r;
   endfunction

endpackage

// ===== src/bb3_line_buf.sv =====
// Paired line buffer: upper and middle rows stored side by side, one entry per column.
`timescale 1ns / 1ps
module bb3_line_buf (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [bb3_pkg::COL_W-1:0]      rd_addr,
   input  logic                           wr_en,
   input  logic [bb3_pkg::COL_W-1:0]      wr_addr,
   input  logic [bb3_pkg::PIX_W-1:0]      wr_pix,
   output logic [bb3_pkg::PIX_W-1:0]      upper_rd,
   output logic [bb3_pkg::PIX_W-1:0]      middle_rd
);

   bb3_pkg::line_pair_type mem [bb3_pkg::MAX_WIDTH];
   bb3_pkg::line_pair_type rd_ff;
   bb3_pkg::line_pair_type wr_in;

   // Middle row moves up, new pixel becomes the middle row.
   always_comb begin
      wr_in.upper  = rd_ff.middle;
      wr_in.middle = wr_pix;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_in;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign upper_rd  = rd_ff.upper;
   assign middle_rd = rd_ff.middle;

endmodule

// ===== src/bb3_col_cell.sv =====
// One window column: holds three pixels, hands them on, and sums the rows inside the frame.
`timescale 1ns / 1ps
module bb3_col_cell (
   input  logic                           clock,
   input  logic                           shift_en,
   input  bb3_pkg::pix3_type              col_in,
   input  logic                           top_en,
   input  logic                           bot_en,
   output bb3_pkg::pix3_type              col_out,
   output logic [bb3_pkg::CSUM_W-1:0]     col_sum
);

   bb3_pkg::pix3_type pix_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff <= col_in;
      end
   end

   always_comb begin
      col_sum = bb3_pkg::CSUM_W'(pix_ff[1])
              + (top_en ? bb3_pkg::CSUM_W'(pix_ff[0]) : '0)
              + (bot_en ? bb3_pkg::CSUM_W'(pix_ff[2]) : '0);
   end

   assign col_out = pix_ff;

endmodule

// ===== src/bb3_norm.sv =====
// Output stage: divide the window sum by 4, 6 or 9 through a reciprocal and hold the result.
`timescale 1ns / 1ps
module bb3_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [bb3_pkg::SUM_W-1:0]     in_sum,
   input  bb3_pkg::cnt_type              in_cnt,
   input  logic                          in_last,
   output logic                          rsp_valid,
   output bb3_pkg::rsp_type              rsp_data
);

   logic [bb3_pkg::PROD_W-1:0] prod;
   logic                       rsp_valid_ff;
   bb3_pkg::rsp_type           rsp_data_ff;
   bb3_pkg::rsp_type           rsp_data_in;

   always_comb begin
      prod = bb3_pkg::PROD_W'(in_sum) * bb3_pkg::PROD_W'(bb3_pkg::recip(in_cnt));
      rsp_data_in.pixel_out  = prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
      rsp_data_in.frame_last = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/box_blur_3x3_edge_normalized.sv =====
// Streaming 3x3 box blur: takes one grey pixel per clock in raster order and returns the
// mean of its in-frame neighborhood (9, 6 or 4 pixels), one result per clock. A result
// leaves via the B, C, D and output registers once its window is complete; in item terms
// output trails input by image_width+1 items, so after the last pixel of a frame send
// image_width+1 flush items (func=1) to drain it. Throughput is set by the single line
// buffer, read and written once per item, and the three-column window shift; the whole
// pipeline holds while a result waits under rsp_stall. Writing either register restarts
// the frame and must happen with the block idle. Registers: width at byte 0, height at 4.
`timescale 1ns / 1ps
module box_blur_3x3_edge_normalized (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bb3_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bb3_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bb3_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [bb3_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [bb3_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int COL_W = bb3_pkg::COL_W;
   localparam int EW    = bb3_pkg::EW;
   localparam int ROW_W = bb3_pkg::ROW_W;
   localparam int HGT_W = bb3_pkg::HGT_W;
   localparam int PIX_W = bb3_pkg::PIX_W;
   localparam int SUM_W = bb3_pkg::SUM_W;

   // configuration
   logic [7:0]       width_ff;
   logic [HGT_W-1:0] height_ff;
   logic             cfg_wr;

   // positions
   logic [COL_W-1:0] in_col_ff,  in_col_in;
   logic [ROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [HGT_W-1:0] out_row_ff, out_row_in;

   logic             adv;
   logic             take;
   logic             item_go;
   logic             tail;
   logic [EW-1:0]    w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [PIX_W-1:0] px;
   bb3_pkg::ctl_type a_ctl;

   // stage B: line buffer read data valid
   bb3_pkg::ctl_type b_ctl_ff;
   logic [COL_W-1:0] b_col_ff;
   logic [PIX_W-1:0] b_px_ff;
   logic [PIX_W-1:0] upper_rd;
   logic [PIX_W-1:0] middle_rd;

   // stage C: window registered in the cells
   bb3_pkg::ctl_type             c_ctl_ff;
   bb3_pkg::ctl_type             c_ctl_in;
   bb3_pkg::pix3_type            link [4];
   logic [bb3_pkg::CSUM_W-1:0]   col_sum [3];
   logic [SUM_W-1:0]             sum;
   bb3_pkg::cnt_type             cnt;

   // stage D: sum registered
   logic             d_valid_ff;
   logic             d_last_ff;
   logic [SUM_W-1:0] d_sum_ff;
   bb3_pkg::cnt_type d_cnt_ff;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign take      = req_valid && adv;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (csr_paddr[2] == bb3_pkg::REG_IDX_HEIGHT) begin
         csr_prdata = bb3_pkg::DATA_W'(height_ff);
      end else begin
         csr_prdata = bb3_pkg::DATA_W'(width_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bb3_pkg::WIDTH_RESET;
         height_ff <= bb3_pkg::HEIGHT_RESET;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == bb3_pkg::REG_IDX_HEIGHT) begin
            height_ff <= csr_pwdata[HGT_W-1:0];
         end else begin
            width_ff <= csr_pwdata[7:0];
         end
      end
   end

   // ---------------- stage A: position tracking ----------------
   always_comb begin
      if (width_ff < 8'd2) begin
         w_eff = EW'(2);
      end else if (32'(width_ff) > bb3_pkg::MAX_WIDTH) begin
         w_eff = EW'(bb3_pkg::MAX_WIDTH);
      end else begin
         w_eff = EW'(width_ff);
      end
      h_eff = (height_ff < HGT_W'(2)) ? HGT_W'(2) : height_ff;

      tail    = in_row_ff >= ROW_W'(h_eff);
      // a flush before the frame is complete does nothing
      item_go = take && !(req_data.func && !tail);
      px      = tail ? '0 : req_data.pixel_in;

      a_ctl.valid    = item_go;
      a_ctl.emit     = (in_row_ff >= ROW_W'(2))
                    || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
      a_ctl.top_en   = out_row_ff != '0;
      a_ctl.bot_en   = (ROW_W'(out_row_ff) + ROW_W'(1)) < ROW_W'(h_eff);
      a_ctl.left_en  = out_col_ff != '0;
      a_ctl.right_en = (EW'(out_col_ff) + EW'(1)) < w_eff;
      a_ctl.last     = !a_ctl.bot_en && !a_ctl.right_en;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (cfg_wr) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (item_go) begin
         if ((EW'(in_col_ff) + EW'(1)) >= w_eff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (a_ctl.emit) begin
            if (a_ctl.last) begin
               // frame done: restart all positions
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!a_ctl.right_en) begin
               out_col_in = '0;
               out_row_in = out_row_ff + HGT_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else if (adv) begin
         b_ctl_ff <= a_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (item_go) begin
         b_col_ff <= in_col_ff;
         b_px_ff  <= px;
      end
   end

   bb3_line_buf u_line_buf (
      .clock     (clock),
      .rd_en     (item_go),
      .rd_addr   (in_col_ff),
      .wr_en     (b_ctl_ff.valid && adv),
      .wr_addr   (b_col_ff),
      .wr_pix    (b_px_ff),
      .upper_rd  (upper_rd),
      .middle_rd (middle_rd)
   );

   // ---------------- stage B/C: column cells ----------------
   assign link[3] = {b_px_ff, middle_rd, upper_rd};

   for (genvar i = 0; i < 3; i++) begin : g_cell
      bb3_col_cell u_cell (
         .clock    (clock),
         .shift_en (b_ctl_ff.valid && adv),
         .col_in   (link[i+1]),
         .top_en   (c_ctl_ff.top_en),
         .bot_en   (c_ctl_ff.bot_en),
         .col_out  (link[i]),
         .col_sum  (col_sum[i])
      );
   end

   always_comb begin
      c_ctl_in       = b_ctl_ff;
      c_ctl_in.valid = b_ctl_ff.valid && b_ctl_ff.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else if (adv) begin
         c_ctl_ff <= c_ctl_in;
      end
   end

   always_comb begin
      sum = SUM_W'(col_sum[1])
          + (c_ctl_ff.left_en  ? SUM_W'(col_sum[0]) : '0)
          + (c_ctl_ff.right_en ? SUM_W'(col_sum[2]) : '0);
      if (c_ctl_ff.top_en && c_ctl_ff.bot_en && c_ctl_ff.left_en && c_ctl_ff.right_en) begin
         cnt = bb3_pkg::CNT_NINE;
      end else if ((c_ctl_ff.top_en && c_ctl_ff.bot_en)
                || (c_ctl_ff.left_en && c_ctl_ff.right_en)) begin
         cnt = bb3_pkg::CNT_SIX;
      end else begin
         cnt = bb3_pkg::CNT_FOUR;
      end
   end

   // ---------------- stage D: normalize ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_last_ff <= c_ctl_ff.last;
         d_sum_ff  <= sum;
         d_cnt_ff  <= cnt;
      end
   end

   bb3_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid_ff),
      .in_sum    (d_sum_ff),
      .in_cnt    (d_cnt_ff),
      .in_last   (d_last_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the streaming 3x3 box blur: random traffic, predicted results.
`timescale 1ns / 1ps
module testbench;
   import bb3_pkg::*;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;
   localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_IDX_WIDTH, 2'b00};
   localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_IDX_HEIGHT, 2'b00};
   localparam int RANDOM_ITEMS = 100;
   localparam int TALL_CUT     = 40;
   localparam int DRAIN_CYCLES = 8;
   localparam int HANG_LIMIT   = 2000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   box_blur_3x3_edge_normalized i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type           pixel_backlog [$];
   rsp_type           blur_expected [$];
   rsp_type           blur_want;
   int                n_queued = 0, n_accepted = 0, errors = 0, stuck_cycles = 0;
   int                req_gap = 0, stall_left = 0;
   bit                calm = 1'b0;
   logic              req_took = 1'b0;
   logic              csr_done = 1'b0;
   logic [DATA_W-1:0] csr_rdata_q = '0;
   int                width_corners [0:6] = '{0, 1, 2, 127, 128, 129, 255};

   // blur predictor state
   logic [7:0]       cfg_width  = WIDTH_RESET;
   logic [HGT_W-1:0] cfg_height = HEIGHT_RESET;
   logic [PIX_W-1:0] upper_row  [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] middle_row [0:MAX_WIDTH-1];
   logic [PIX_W-1:0] nbhd [0:2][0:2];
   int               src_col = 0, src_row = 0, dst_col = 0, dst_row = 0;

   function automatic int eff_width(input logic [7:0] v);
      if (v < 2) return 2;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   function automatic int eff_height(input logic [HGT_W-1:0] v);
      return (v < 2) ? 2 : v;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_idle(input bit quiet);
      int roll;
      roll = $urandom_range(99);
      if (quiet || roll < 55) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom_range(255);
   endfunction

   task automatic restart_position();
      src_col = 0;
      src_row = 0;
      dst_col = 0;
      dst_row = 0;
   endtask

   task automatic blur_predict(input req_type item);
      int               w, h, r, k, r0, r1, k0, k1, sum, count;
      logic             tail_tick, emit;
      logic [PIX_W-1:0] v;
      rsp_type          res;
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      tail_tick = (src_row >= h);
      // drop a stray flush while the frame is still coming in
      if (item.func == FUNC_FLUSH && !tail_tick) return;
      v = tail_tick ? '0 : item.pixel_in;
      for (r = 0; r < 3; r++) begin
         nbhd[r][0] = nbhd[r][1];
         nbhd[r][1] = nbhd[r][2];
      end
      nbhd[0][2] = upper_row[src_col];
      nbhd[1][2] = middle_row[src_col];
      nbhd[2][2] = v;
      upper_row[src_col]  = middle_row[src_col];
      middle_row[src_col] = v;
      emit = (src_row >= 2) || (src_row == 1 && src_col >= 1);
      src_col++;
      if (src_col >= w) begin
         src_col = 0;
         src_row++;
      end
      if (!emit) return;
      // keep only window rows and columns that lie inside the frame
      r0 = (dst_row >= 1) ? 0 : 1;
      r1 = (dst_row + 1 < h) ? 2 : 1;
      k0 = (dst_col >= 1) ? 0 : 1;
      k1 = (dst_col + 1 < w) ? 2 : 1;
      sum = 0;
      for (r = r0; r <= r1; r++)
         for (k = k0; k <= k1; k++)
            sum += nbhd[r][k];
      count = (r1 - r0 + 1) * (k1 - k0 + 1);
      res.pixel_out  = PIX_W'(sum / count);
      res.frame_last = (dst_row + 1 >= h) && (dst_col + 1 >= w);
      blur_expected.push_back(res);
      if (res.frame_last) begin
         restart_position();
      end else begin
         dst_col++;
         if (dst_col >= w) begin
            dst_col = 0;
            dst_row++;
         end
      end
   endtask

   // Input driver: hold each item until its transfer, then idle for the chosen gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pixel_backlog.size() != 0) begin
            req_data  <= pixel_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_idle(calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_idle(calm);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Monitor: predict on each input transfer, check each result transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_took     <= 1'b0;
         csr_done     <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         req_took    <= req_valid && !req_stall;
         csr_done    <= csr_psel && csr_penable && csr_pready;
         csr_rdata_q <= csr_prdata;
         if (req_valid && !req_stall) begin
            blur_predict(req_data);
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (blur_expected.size() == 0) begin
               $display("%0t: result with none expected: pixel_out %0d frame_last %0b",
                        $time, rsp_data.pixel_out, rsp_data.frame_last);
               errors++;
            end else begin
               blur_want = blur_expected.pop_front();
               if (rsp_data.pixel_out !== blur_want.pixel_out) begin
                  $display("%0t: pixel_out expected %0d, actual %0d",
                           $time, blur_want.pixel_out, rsp_data.pixel_out);
                  errors++;
               end
               if (rsp_data.frame_last !== blur_want.frame_last) begin
                  $display("%0t: frame_last expected %0b, actual %0b",
                           $time, blur_want.frame_last, rsp_data.frame_last);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("Verification failed");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   task automatic csr_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_done);
      rdata = csr_rdata_q;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_check(input logic [ADDR_W-1:0] addr);
      logic [DATA_W-1:0] got, want;
      csr_access(1'b0, addr, '0, got);
      want = (addr == WIDTH_ADDR) ? DATA_W'(cfg_width) : DATA_W'(cfg_height);
      if (got !== want) begin
         $display("%0t: register %0d read expected %0d, actual %0d", $time, addr, want, got);
         errors++;
      end
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] ignored_rdata;
      csr_access(1'b1, addr, data, ignored_rdata);
      if (addr == WIDTH_ADDR) cfg_width = data[7:0];
      else cfg_height = data[HGT_W-1:0];
      // any register write restarts the frame
      restart_position();
      csr_check(addr);
   endtask

   task automatic queue_item(input logic func, input logic [PIX_W-1:0] pix);
      req_type item;
      item.func     = func;
      item.pixel_in = pix;
      pixel_backlog.push_back(item);
      n_queued++;
   endtask

   // Frame pixels with a few stray flushes, then tail ticks, some of them pixel items.
   task automatic queue_frame(input int pixels, input int tail_len);
      int i;
      for (i = 0; i < pixels; i++) begin
         if ($urandom_range(99) < 5) queue_item(FUNC_FLUSH, pick_pixel());
         queue_item(FUNC_PIXEL, pick_pixel());
      end
      for (i = 0; i < tail_len; i++)
         queue_item(($urandom_range(99) < 25) ? FUNC_PIXEL : FUNC_FLUSH, pick_pixel());
   endtask

   // Hold off until every item is in and every result is out, then let the pipe settle.
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || n_accepted != n_queued || blur_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int i, roll, wval, hval, w_now, h_now, n_cut, random_items;
      bit restart_due;
      for (i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (i = 0; i < 9; i++) nbhd[i / 3][i % 3] = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      csr_check(WIDTH_ADDR);
      csr_check(HEIGHT_ADDR);

      // 2x2 frame from out-of-range sizes, stray flush mid-frame, pixel in the tail
      csr_write(WIDTH_ADDR, 32'd0);
      csr_write(HEIGHT_ADDR, 32'd1);
      queue_item(FUNC_PIXEL, 8'd255);
      queue_item(FUNC_FLUSH, 8'd255);
      queue_item(FUNC_PIXEL, 8'd0);
      queue_item(FUNC_PIXEL, 8'd255);
      queue_item(FUNC_PIXEL, 8'd1);
      queue_item(FUNC_FLUSH, 8'd0);
      queue_item(FUNC_PIXEL, 8'd128);
      queue_item(FUNC_FLUSH, 8'd127);
      wait_drained();

      // full-scale 3x3: corners, edges and the center all give the top value
      csr_write(WIDTH_ADDR, 32'd3);
      csr_write(HEIGHT_ADDR, 32'd3);
      for (i = 0; i < 9; i++) queue_item(FUNC_PIXEL, 8'hFF);
      for (i = 0; i < 4; i++) queue_item(FUNC_FLUSH, 8'h00);
      wait_drained();

      // widest rows, then the top rows of the tallest frame at minimum width, cut short
      csr_write(WIDTH_ADDR, 32'hFFFF_FFFF);
      csr_write(HEIGHT_ADDR, 32'hFFFF_F002);
      queue_frame(MAX_WIDTH * 2, MAX_WIDTH + 1);
      wait_drained();
      csr_write(WIDTH_ADDR, 32'h0000_0101);
      csr_write(HEIGHT_ADDR, 32'hFFFF_FFFF);
      queue_frame(TALL_CUT, 0);
      wait_drained();

      // the tall frame is unfinished, so start with a register write
      restart_due = 1'b1;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_drained();
         calm = ($urandom_range(3) == 0);
         if (restart_due || $urandom_range(1) == 0) begin
            roll = $urandom_range(99);
            if (roll < 8) wval = width_corners[$urandom_range(6)];
            else if (roll < 25) wval = $urandom_range(40, 10);
            else wval = $urandom_range(9, 2);
            roll = $urandom_range(99);
            if (roll < 10) hval = $urandom_range(1, 0);
            else if (roll < 25) hval = $urandom_range(12, 7);
            else hval = $urandom_range(6, 2);
            // keep wide frames short
            if (eff_width(wval) > 40) hval = $urandom_range(3, 0);
            csr_write(WIDTH_ADDR, ($urandom & 32'hFFFF_FF00) | wval);
            csr_write(HEIGHT_ADDR, ($urandom & 32'hFFFF_F000) | hval);
            restart_due = 1'b0;
         end
         w_now = eff_width(cfg_width);
         h_now = eff_height(cfg_height);
         if ($urandom_range(99) < 15) begin
            // cut the frame short; the next register write restarts it
            n_cut = $urandom_range(w_now * h_now + w_now, 1);
            queue_frame((n_cut < w_now * h_now) ? n_cut : w_now * h_now,
                        (n_cut > w_now * h_now) ? n_cut - w_now * h_now : 0);
            random_items += n_cut;
            restart_due = 1'b1;
         end else begin
            queue_frame(w_now * h_now, w_now + 1);
            random_items += w_now * (h_now + 1) + 1;
         end
      end
      wait_drained();

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
